// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the formatter RTL.
// Needs i_clk and i_rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked outside reset.
`define FPSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define FPSS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FPSS_ASSERT(label, prop, msg)
`define FPSS_ASSERT_RST(label, prop, msg)
`endif
`endif

// ----- hdl/fpss_pkg.sv -----
// Package for the fixed-point seven-segment formatter.
// Widths, segment codes, stage payload types and small lookup functions.
`default_nettype none
package fpss_pkg;

    localparam int FRAC_BITS  = 20;
    localparam int INT_BITS   = 24;
    localparam int VALUE_W    = INT_BITS + FRAC_BITS + 1;
    localparam int IP_W       = VALUE_W - FRAC_BITS;
    localparam int BIN_W      = 24;
    localparam int POW_W      = 20;
    localparam int NUM_DIGITS = 7;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = 3;
    localparam int DD_STEPS   = 6;
    localparam int DD_STAGES  = BIN_W / DD_STEPS;

    localparam logic [BIN_W-1:0] OVER_LIMIT = 24'd9999999;

    localparam logic [7:0] SEG_A = 8'd64;
    localparam logic [7:0] SEG_D = 8'd8;
    localparam logic [7:0] SEG_G = 8'd1;
    localparam logic [7:0] SEG_P = 8'd128;
    localparam logic [7:0] SEG_BLANK = 8'd0;

    typedef logic [CNT_W-1:0] t_pos;
    typedef logic [NUM_DIGITS-1:0][7:0] t_segs;

    // after magnitude
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_s1;

    // after range check
    typedef struct packed {
        logic                 neg;
        logic                 over;
        t_pos                 n;
        logic [BIN_W-1:0]     ip;
        logic [FRAC_BITS-1:0] fr;
    } t_s2;

    // after scaling products
    typedef struct packed {
        logic             neg;
        logic             over;
        t_pos             n;
        logic [BIN_W-1:0] pi;
        logic [POW_W-1:0] pf;
    } t_s3;

    // double dabble working item
    typedef struct packed {
        logic             neg;
        logic             over;
        t_pos             n;
        logic [BIN_W-1:0] bin;
        logic [BCD_W-1:0] bcd;
    } t_dd;

    function automatic logic [POW_W-1:0] pow10(input t_pos k);
        logic [POW_W-1:0] r;
        case (k)
            3'd0:    r = 20'd1;
            3'd1:    r = 20'd10;
            3'd2:    r = 20'd100;
            3'd3:    r = 20'd1000;
            3'd4:    r = 20'd10000;
            3'd5:    r = 20'd100000;
            3'd6:    r = 20'd1000000;
            default: r = 20'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] r;
        case (d)
            4'd0:    r = 8'd126;
            4'd1:    r = 8'd48;
            4'd2:    r = 8'd109;
            4'd3:    r = 8'd121;
            4'd4:    r = 8'd51;
            4'd5:    r = 8'd91;
            4'd6:    r = 8'd95;
            4'd7:    r = 8'd112;
            4'd8:    r = 8'd127;
            4'd9:    r = 8'd123;
            default: r = SEG_BLANK;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/fpss_range.sv -----
// Stages 1-2: magnitude, integer digit count and overflow check.
// Uses fpss_pkg.
`default_nettype none
module fpss_range (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    input  wire signed [fpss_pkg::VALUE_W-1:0] i_value,
    output logic                              o_ready,
    output logic                              o_valid,
    output fpss_pkg::t_s2                     o_data,
    input  wire                               i_ready
);
    import fpss_pkg::*;

    logic         r_v1, r_v2;
    t_s1          r_s1, n_s1;
    t_s2          r_s2, n_s2;
    logic         w_rdy1, w_rdy2;
    logic [VALUE_W-1:0] w_raw;
    logic [IP_W-1:0]    w_ip;
    t_pos               w_cnt;

    assign w_rdy2 = !r_v2 || i_ready;
    assign w_rdy1 = !r_v1 || w_rdy2;

    // |value|; the most negative code maps to 2^(VALUE_W-1) exactly
    always_comb begin
        w_raw      = i_value;
        n_s1.neg   = w_raw[VALUE_W-1];
        n_s1.mag   = w_raw[VALUE_W-1] ? (~w_raw + VALUE_W'(1)) : w_raw;
    end

    // digits in integer part: 1 + number of powers of ten it reaches
    always_comb begin
        w_ip  = r_s1.mag[VALUE_W-1:FRAC_BITS];
        w_cnt = CNT_W'(1);
        for (int j = 1; j < NUM_DIGITS; j++) begin
            if (w_ip >= IP_W'(pow10(CNT_W'(j)))) begin
                w_cnt = w_cnt + CNT_W'(1);
            end
        end
        n_s2.neg  = r_s1.neg;
        n_s2.over = w_ip > IP_W'(OVER_LIMIT);
        n_s2.n    = w_cnt;
        n_s2.ip   = w_ip[BIN_W-1:0];
        n_s2.fr   = r_s1.mag[FRAC_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) r_s1 <= n_s1;
        if (w_rdy2 && r_v1)    r_s2 <= n_s2;
    end

    assign o_ready = w_rdy1;
    assign o_valid = r_v2;
    assign o_data  = r_s2;

endmodule
`default_nettype wire

// ----- hdl/fpss_scale.sv -----
// Stages 3-4: scales integer and fraction parts by 10^k and joins them
// into one 7-digit binary number. Uses fpss_pkg.
`default_nettype none
module fpss_scale (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    input  fpss_pkg::t_s2 i_data,
    output logic          o_ready,
    output logic          o_valid,
    output fpss_pkg::t_dd o_data,
    input  wire           i_ready
);
    import fpss_pkg::*;

    logic r_v3, r_v4;
    t_s3  r_s3, n_s3;
    t_dd  r_s4, n_s4;
    logic w_rdy3, w_rdy4;
    logic [POW_W-1:0]           w_pow;
    logic [BIN_W+POW_W-1:0]     w_pi_full;
    logic [FRAC_BITS+POW_W-1:0] w_pf_full;

    assign w_rdy4 = !r_v4 || i_ready;
    assign w_rdy3 = !r_v3 || w_rdy4;

    // k = fraction positions left after the integer digits
    always_comb begin
        w_pow     = pow10(CNT_W'(NUM_DIGITS) - i_data.n);
        w_pi_full = i_data.ip * w_pow;
        w_pf_full = i_data.fr * w_pow;
        n_s3.neg  = i_data.neg;
        n_s3.over = i_data.over;
        n_s3.n    = i_data.n;
        n_s3.pi   = w_pi_full[BIN_W-1:0];
        n_s3.pf   = w_pf_full[FRAC_BITS+POW_W-1:FRAC_BITS];
    end

    always_comb begin
        n_s4.neg  = r_s3.neg;
        n_s4.over = r_s3.over;
        n_s4.n    = r_s3.n;
        n_s4.bin  = r_s3.pi + BIN_W'(r_s3.pf);
        n_s4.bcd  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy3) r_v3 <= i_valid;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && i_valid) r_s3 <= n_s3;
        if (w_rdy4 && r_v3)    r_s4 <= n_s4;
    end

    assign o_ready = w_rdy3;
    assign o_valid = r_v4;
    assign o_data  = r_s4;

endmodule
`default_nettype wire

// ----- hdl/fpss_dabble.sv -----
// One double-dabble stage: shifts DD_STEPS binary bits into the BCD word.
// Uses fpss_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fpss_dabble (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    input  fpss_pkg::t_dd i_data,
    output logic          o_ready,
    output logic          o_valid,
    output fpss_pkg::t_dd o_data,
    input  wire           i_ready
);
    import fpss_pkg::*;

    logic r_valid;
    t_dd  r_data, n_data;
    logic w_rdy;
    logic w_bcd_ok;

    assign w_rdy = !r_valid || i_ready;

    always_comb begin
        logic [BCD_W-1:0] v_bcd;
        logic [BIN_W-1:0] v_bin;
        v_bcd = i_data.bcd;
        v_bin = i_data.bin;
        for (int s = 0; s < DD_STEPS; s++) begin
            for (int g = 0; g < NUM_DIGITS; g++) begin
                if (v_bcd[4*g +: 4] >= 4'd5) begin
                    v_bcd[4*g +: 4] = v_bcd[4*g +: 4] + 4'd3;
                end
            end
            v_bcd = {v_bcd[BCD_W-2:0], v_bin[BIN_W-1]};
            v_bin = {v_bin[BIN_W-2:0], 1'b0};
        end
        n_data      = i_data;
        n_data.bcd  = v_bcd;
        n_data.bin  = v_bin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_valid) r_data <= n_data;
    end

    assign o_ready = w_rdy;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        w_bcd_ok = 1'b1;
        for (int g = 0; g < NUM_DIGITS; g++) begin
            if (r_data.bcd[4*g +: 4] > 4'd9) w_bcd_ok = 1'b0;
        end
    end

    `FPSS_ASSERT(a_bcd_digits, r_valid |-> w_bcd_ok, "dabble stage produced a non-decimal digit")

endmodule
`default_nettype wire

// ----- hdl/fpss_encode.sv -----
// Output stage: BCD digits to segment patterns, point and overflow marks.
// Uses fpss_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fpss_encode (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  fpss_pkg::t_dd   i_data,
    output logic            o_ready,
    output logic            o_valid,
    output logic [7:0]      o_sign,
    output fpss_pkg::t_segs o_segs,
    input  wire             i_ready
);
    import fpss_pkg::*;

    logic       r_valid;
    logic [7:0] r_sign, n_sign;
    t_segs      r_segs, n_segs;
    logic       w_rdy;
    logic [NUM_DIGITS-1:0] w_points;

    assign w_rdy = !r_valid || i_ready;

    // entry 0 is display position 1 (most significant digit)
    always_comb begin
        n_sign = i_data.neg ? SEG_G : SEG_BLANK;
        for (int p = 0; p < NUM_DIGITS; p++) begin
            n_segs[p] = seg_of(i_data.bcd[4*(NUM_DIGITS-1-p) +: 4]);
            if (CNT_W'(p + 1) == i_data.n) begin
                n_segs[p] = n_segs[p] | SEG_P;
            end
            if (i_data.over) begin
                n_segs[p] = i_data.neg ? SEG_D : SEG_A;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_valid) begin
            r_sign <= n_sign;
            r_segs <= n_segs;
        end
    end

    assign o_ready = w_rdy;
    assign o_valid = r_valid;
    assign o_sign  = r_sign;
    assign o_segs  = r_segs;

    always_comb begin
        for (int p = 0; p < NUM_DIGITS; p++) begin
            w_points[p] = r_segs[p][7];
        end
    end

    `FPSS_ASSERT(a_one_point, r_valid |-> $onehot0(w_points), "more than one decimal point lit")
    `FPSS_ASSERT(a_sign_code, r_valid |-> (r_sign == SEG_G || r_sign == SEG_BLANK), "bad sign pattern")

endmodule
`default_nettype wire

// ----- hdl/fixed_point_seven_segment_formatter.sv -----
// Fixed-point seven-segment formatter, top level.
// Pipeline stages: range 2, scale 2, double dabble 4, segment encode 1.
// Throughput: one item per cycle while the output is not stalled.
// Every stage has its own valid bit; a stage refills whenever it is empty or
// its successor moves, so bubbles collapse while the output is stalled.
// Reset (i_rst_n low, synchronous) clears all valid bits; no payload reset.
`default_nettype none
`include "assert_macros.svh"
module fixed_point_seven_segment_formatter (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // input channel
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire signed [fpss_pkg::VALUE_W-1:0] i_value,
    // result channel
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic [7:0]                         o_digit_sign,
    output logic [7:0]                         o_digit_one,
    output logic [7:0]                         o_digit_two,
    output logic [7:0]                         o_digit_three,
    output logic [7:0]                         o_digit_four,
    output logic [7:0]                         o_digit_five,
    output logic [7:0]                         o_digit_six,
    output logic [7:0]                         o_digit_seven
);
    import fpss_pkg::*;

    // stage handshake wiring
    logic w_rng_ready, w_rng_valid;
    t_s2  w_rng_data;
    logic w_scl_ready;

    // dabble chain: index 0 is the scale output, DD_STAGES the last stage
    logic w_dd_valid [DD_STAGES+1];
    logic w_dd_ready [DD_STAGES+1];
    t_dd  w_dd_data  [DD_STAGES+1];

    logic  w_enc_ready;
    t_segs w_segs;

    fpss_range u_range (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_value (i_value),
        .o_ready (w_rng_ready),
        .o_valid (w_rng_valid),
        .o_data  (w_rng_data),
        .i_ready (w_scl_ready)
    );

    // integer and fraction scaled into one number below 10^7 when in range
    fpss_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rng_valid),
        .i_data  (w_rng_data),
        .o_ready (w_scl_ready),
        .o_valid (w_dd_valid[0]),
        .o_data  (w_dd_data[0]),
        .i_ready (w_dd_ready[0])
    );

    // binary to BCD, DD_STEPS bits per stage
    for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
        fpss_dabble u_dabble (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dd_valid[g]),
            .i_data  (w_dd_data[g]),
            .o_ready (w_dd_ready[g]),
            .o_valid (w_dd_valid[g+1]),
            .o_data  (w_dd_data[g+1]),
            .i_ready (w_dd_ready[g+1])
        );
    end

    assign w_dd_ready[DD_STAGES] = w_enc_ready;

    // result register doubles as the output stage
    fpss_encode u_encode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dd_valid[DD_STAGES]),
        .i_data  (w_dd_data[DD_STAGES]),
        .o_ready (w_enc_ready),
        .o_valid (o_out_valid),
        .o_sign  (o_digit_sign),
        .o_segs  (w_segs),
        .i_ready (!i_out_stall)
    );

    assign o_in_stall    = !w_rng_ready;
    assign o_digit_one   = w_segs[0];
    assign o_digit_two   = w_segs[1];
    assign o_digit_three = w_segs[2];
    assign o_digit_four  = w_segs[3];
    assign o_digit_five  = w_segs[4];
    assign o_digit_six   = w_segs[5];
    assign o_digit_seven = w_segs[6];

    `FPSS_ASSERT_RST(a_reset_empties, !i_rst_n |=> !o_out_valid, "result valid right after reset")
    `FPSS_ASSERT(a_free_flow, !i_out_stall |-> !o_in_stall, "input stalled with output free")

endmodule
`default_nettype wire
